### hdl/led_ring_diagnostic_sequencer_top_defines.svh
// assertion macros used by the checker module lrds_chk
`ifndef LED_RING_DIAGNOSTIC_SEQUENCER_TOP_DEFINES_SVH
`define LED_RING_DIAGNOSTIC_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LRDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define LRDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/lrds_pkg.sv
`timescale 1ns / 1ps
package lrds_pkg;

	localparam int TIME_BITS = 32;
	localparam int SPAN_BITS = 24;
	localparam int STEP_BITS = 16;
	localparam int DIV_BITS  = 24;

	localparam logic [7:0] RING_PIXELS = 8'd16;
	localparam logic [7:0] SOC_PIXELS  = 8'd8;

	localparam logic [STEP_BITS-1:0] CHASE_STEP_RST = 16'd100;
	localparam logic [STEP_BITS-1:0] BAR_STEP_RST   = 16'd250;
	localparam logic [SPAN_BITS-1:0] BAR_LEG_RST    = 24'd2000;
	localparam logic [SPAN_BITS-1:0] BAR_PAUSE_RST  = 24'd500;
	localparam logic [SPAN_BITS-1:0] BAR_TOTAL_RST  = 24'd5000;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_CHASE = 2'd1;
	localparam logic [1:0] REQ_BAR   = 2'd2;
	localparam logic [1:0] REQ_OFF   = 2'd3;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_CLEAR  = 2'd1;
	localparam logic [1:0] ACT_MARKER = 2'd2;
	localparam logic [1:0] ACT_BAR    = 2'd3;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_CHASE = 2'd1;
	localparam logic [1:0] MODE_BAR   = 2'd2;

	localparam logic [2:0] CFG_RAIL        = 3'd0;
	localparam logic [2:0] CFG_CHASE_STEP  = 3'd1;
	localparam logic [2:0] CFG_BAR_STEP    = 3'd2;
	localparam logic [2:0] CFG_BAR_LEG     = 3'd3;
	localparam logic [2:0] CFG_BAR_PAUSE   = 3'd4;
	localparam logic [2:0] CFG_BAR_TOTAL   = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TIME,
		ST_DIV,
		ST_FIN
	} lrds_state_t;

	// comparison results of the serial time pass
	typedef struct packed {
		logic neg;       // elapsed wrapped past half range
		logic ge_step;   // elapsed >= chase step
		logic ge_leg;    // elapsed >= rising leg
		logic ge_hold;   // elapsed >= leg + pause
		logic ge_total;  // elapsed >= total duration
	} lrds_tflags_t;

endpackage

### hdl/lrds_tsub.sv
`timescale 1ns / 1ps
module lrds_tsub (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [31:0]           now_ms,
	input  logic [31:0]           base_ms,
	input  logic [23:0]           leg_ms,
	input  logic [23:0]           pause_ms,
	input  logic [23:0]           total_ms,
	input  logic [15:0]           step_ms,
	output logic                  done,
	output lrds_pkg::lrds_tflags_t flags,
	output logic [23:0]           elapsed,
	output logic [23:0]           fall
);
	import lrds_pkg::*;

	logic [TIME_BITS-1:0] now_q, base_q, el_q;
	logic [SPAN_BITS-1:0] leg_q, pause_q, total_q, fa_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 eb_q, hc_q, fb_q;
	logic                 ge_step_q, ge_leg_q, ge_hold_q, ge_total_q;
	logic [4:0]           cnt_q;
	logic                 busy_q, done_q;

	logic e_bit, eb_d, h_bit, hc_d, f_bit, fb_d, last;

	// lsb-first: elapsed = now - base, hold_end = leg + pause, fall = elapsed - hold_end
	always_comb begin
		e_bit = now_q[0] ^ base_q[0] ^ eb_q;
		eb_d  = (~now_q[0] & base_q[0]) | (~(now_q[0] ^ base_q[0]) & eb_q);
		h_bit = leg_q[0] ^ pause_q[0] ^ hc_q;
		hc_d  = (leg_q[0] & pause_q[0]) | ((leg_q[0] ^ pause_q[0]) & hc_q);
		f_bit = e_bit ^ h_bit ^ fb_q;
		fb_d  = (~e_bit & h_bit) | (~(e_bit ^ h_bit) & fb_q);
		last  = (cnt_q == 5'(TIME_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			now_q      <= now_ms;
			base_q     <= base_ms;
			leg_q      <= leg_ms;
			pause_q    <= pause_ms;
			total_q    <= total_ms;
			step_q     <= step_ms;
			eb_q       <= 1'b0;
			hc_q       <= 1'b0;
			fb_q       <= 1'b0;
			ge_step_q  <= 1'b1;
			ge_leg_q   <= 1'b1;
			ge_hold_q  <= 1'b1;
			ge_total_q <= 1'b1;
		end else if (busy_q) begin
			now_q   <= now_q >> 1;
			base_q  <= base_q >> 1;
			leg_q   <= leg_q >> 1;
			pause_q <= pause_q >> 1;
			total_q <= total_q >> 1;
			step_q  <= step_q >> 1;
			eb_q    <= eb_d;
			hc_q    <= hc_d;
			fb_q    <= fb_d;
			// a differing bit decides, the higher one last
			if (e_bit != step_q[0])  ge_step_q  <= e_bit;
			if (e_bit != leg_q[0])   ge_leg_q   <= e_bit;
			if (e_bit != h_bit)      ge_hold_q  <= e_bit;
			if (e_bit != total_q[0]) ge_total_q <= e_bit;
			el_q <= {e_bit, el_q[TIME_BITS-1:1]};
			if (cnt_q < 5'(SPAN_BITS)) begin
				fa_q <= {f_bit, fa_q[SPAN_BITS-1:1]};
			end
		end
	end

	assign done           = done_q;
	assign flags.neg      = el_q[TIME_BITS-1];
	assign flags.ge_step  = ge_step_q;
	assign flags.ge_leg   = ge_leg_q;
	assign flags.ge_hold  = ge_hold_q;
	assign flags.ge_total = ge_total_q;
	assign elapsed        = el_q[SPAN_BITS-1:0];
	assign fall           = fa_q;

endmodule

### hdl/lrds_div.sv
`timescale 1ns / 1ps
module lrds_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	import lrds_pkg::*;

	logic [DIV_BITS-1:0]  dvd_q, quo_q;
	logic [STEP_BITS-1:0] dvs_q, rem_q;
	logic [4:0]           cnt_q;
	logic                 busy_q, done_q;

	logic [STEP_BITS:0]   rem2;
	logic                 fits;
	logic [STEP_BITS-1:0] rem_d;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem2  = {rem_q, dvd_q[DIV_BITS-1]};
		fits  = (rem2 >= {1'b0, dvs_q});
		rem_d = fits ? STEP_BITS'(rem2 - {1'b0, dvs_q}) : rem2[STEP_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'(DIV_BITS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_d;
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/led_ring_diagnostic_sequencer_top.sv
`timescale 1ns / 1ps
// LED ring diagnostic sequencer: each item on the s_ side is a request (tick, start chase,
// start bar test, off) with a wrapping millisecond time stamp, and gives exactly one result
// item on the m_ side telling which frame to draw. One item is worked on at a time. Starts,
// offs, and ticks while idle or unpowered go straight to the result stage; a running tick
// goes through a 32-bit bit-serial pass that forms the elapsed time and all its comparisons,
// and a bar tick that needs a segment count then runs a 24-bit restoring divider by the bar
// step. A new item is taken while the previous result still sits in the output register.
// Configuration is written through the cfg_ port, always ready; the user must write it only
// while no item is in progress, as the block itself does not enforce this.
module led_ring_diagnostic_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // now_ms
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // marker_index, bar_segments, accepted, mode_now, zero pad
	output logic [1:0]  m_tuser,   // action
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import lrds_pkg::*;

	lrds_state_t state_q, state_d;

	logic                 rail_q;
	logic [STEP_BITS-1:0] chase_step_q, bar_step_q;
	logic [SPAN_BITS-1:0] bar_leg_q, bar_pause_q, bar_total_q;

	logic [1:0]           mode_q;
	logic [7:0]           pos_q;
	logic [TIME_BITS-1:0] chase_last_q, bar_start_q, now_q;
	logic [7:0]           shown_q;
	logic                 fall_q;

	logic [1:0]           res_action_q;
	logic [7:0]           res_marker_q, res_segs_q;
	logic                 res_acc_q;
	logic                 m_valid_q;
	logic [23:0]          m_data_q;
	logic [1:0]           m_user_q;

	logic                 in_acc, go_time, t_start, fin_load;
	logic                 t_done, d_done;
	lrds_tflags_t         tflags;
	logic [SPAN_BITS-1:0] t_elapsed, t_fall;
	logic [DIV_BITS-1:0]  d_quo;
	logic                 bar_live, div_start, hold_hit, bar_upd, bar_new;
	logic [7:0]           bar_cnt;
	logic [STEP_BITS-1:0] divisor;

	lrds_tsub u_tsub (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (t_start),
		.now_ms   (s_tdata),
		.base_ms  ((mode_q == MODE_BAR) ? bar_start_q : chase_last_q),
		.leg_ms   (bar_leg_q),
		.pause_ms (bar_pause_q),
		.total_ms (bar_total_q),
		.step_ms  (chase_step_q),
		.done     (t_done),
		.flags    (tflags),
		.elapsed  (t_elapsed),
		.fall     (t_fall)
	);

	assign divisor = (bar_step_q == '0) ? STEP_BITS'(1) : bar_step_q;

	lrds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tflags.ge_leg ? t_fall : t_elapsed),
		.divisor  (divisor),
		.done     (d_done),
		.quotient (d_quo)
	);

	always_comb begin
		go_time = (s_tuser == REQ_TICK) && (mode_q != MODE_IDLE) && rail_q;
		// bar tick inside the test window
		bar_live  = t_done && (state_q == ST_TIME) && (mode_q == MODE_BAR) && !tflags.neg
			&& !tflags.ge_total;
		div_start = bar_live && (!tflags.ge_leg || tflags.ge_hold);
		hold_hit  = bar_live && tflags.ge_leg && !tflags.ge_hold;
		bar_upd   = hold_hit || ((state_q == ST_DIV) && d_done);
		if (state_q != ST_DIV) begin
			bar_cnt = SOC_PIXELS;
		end else if (fall_q) begin
			bar_cnt = (d_quo >= DIV_BITS'(SOC_PIXELS)) ? 8'd0 : SOC_PIXELS - d_quo[7:0];
		end else begin
			bar_cnt = (d_quo > DIV_BITS'(SOC_PIXELS)) ? SOC_PIXELS : d_quo[7:0];
		end
		bar_new = bar_upd && (bar_cnt != shown_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = go_time ? ST_TIME : ST_FIN;
			end
			ST_TIME: if (t_done) begin
				state_d = div_start ? ST_DIV : ST_FIN;
			end
			ST_DIV: if (d_done) begin
				state_d = ST_FIN;
			end
			ST_FIN: if (!m_valid_q || m_tready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_FIN:  fin_load = !m_valid_q || m_tready;
			default: ;
		endcase
		in_acc  = s_tvalid && s_tready;
		t_start = in_acc && go_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rail_q       <= 1'b1;
			chase_step_q <= CHASE_STEP_RST;
			bar_step_q   <= BAR_STEP_RST;
			bar_leg_q    <= BAR_LEG_RST;
			bar_pause_q  <= BAR_PAUSE_RST;
			bar_total_q  <= BAR_TOTAL_RST;
			mode_q       <= MODE_IDLE;
			pos_q        <= '0;
			chase_last_q <= '0;
			bar_start_q  <= '0;
			shown_q      <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_RAIL:       rail_q       <= cfg_data[0];
					CFG_CHASE_STEP: chase_step_q <= cfg_data[STEP_BITS-1:0];
					CFG_BAR_STEP:   bar_step_q   <= cfg_data[STEP_BITS-1:0];
					CFG_BAR_LEG:    bar_leg_q    <= cfg_data;
					CFG_BAR_PAUSE:  bar_pause_q  <= cfg_data;
					CFG_BAR_TOTAL:  bar_total_q  <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				case (s_tuser)
					REQ_CHASE: if (rail_q) begin
						mode_q       <= MODE_CHASE;
						pos_q        <= '0;
						chase_last_q <= s_tdata;
					end
					REQ_BAR: if (rail_q) begin
						mode_q      <= MODE_BAR;
						bar_start_q <= s_tdata;
						shown_q     <= '0;
					end
					REQ_OFF: mode_q <= MODE_IDLE;
					default: if (!rail_q) begin
						mode_q <= MODE_IDLE;
					end
				endcase
			end
			if (t_done && (state_q == ST_TIME)) begin
				if (mode_q == MODE_CHASE) begin
					if (tflags.ge_step) begin
						chase_last_q <= now_q;
						if (pos_q >= RING_PIXELS) begin
							mode_q <= MODE_IDLE;
						end else begin
							pos_q <= pos_q + 8'd1;
						end
					end
				end else if (!tflags.neg && tflags.ge_total) begin
					mode_q <= MODE_IDLE;
				end
			end
			if (bar_new) begin
				shown_q <= bar_cnt;
			end
			if (fin_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q        <= s_tdata;
			res_action_q <= ACT_NONE;
			res_marker_q <= '0;
			res_segs_q   <= '0;
			res_acc_q    <= 1'b0;
			case (s_tuser)
				REQ_CHASE: if (rail_q) begin
					res_acc_q    <= 1'b1;
					res_action_q <= ACT_CLEAR;
				end
				REQ_BAR: if (rail_q) begin
					res_acc_q    <= 1'b1;
					res_action_q <= ACT_BAR;
				end
				REQ_OFF: if (rail_q) begin
					res_action_q <= ACT_CLEAR;
				end
				default: ;
			endcase
		end
		if (t_done && (state_q == ST_TIME)) begin
			fall_q <= tflags.ge_leg;
			if (mode_q == MODE_CHASE) begin
				if (tflags.ge_step) begin
					if (pos_q >= RING_PIXELS) begin
						res_action_q <= ACT_CLEAR;
					end else begin
						res_action_q <= ACT_MARKER;
						res_marker_q <= pos_q;
					end
				end
			end else if (!tflags.neg && tflags.ge_total) begin
				res_action_q <= ACT_CLEAR;
			end
		end
		if (bar_new) begin
			res_action_q <= ACT_BAR;
			res_segs_q   <= bar_cnt;
		end
		if (fin_load) begin
			m_user_q <= res_action_q;
			m_data_q <= {5'd0, mode_q, res_acc_q, res_segs_q, res_marker_q};
		end
	end

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_user_q;
	assign cfg_ready = 1'b1;

endmodule

### hdl/lrds_chk.sv
`timescale 1ns / 1ps
`include "led_ring_diagnostic_sequencer_top_defines.svh"
module lrds_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import lrds_pkg::*;

	// one item in flight: after an accept the input side closes
	`LRDS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while busy")

	`LRDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// a marker frame only while chasing, and inside the ring
	`LRDS_ASSERT_NOW(a_marker_mode, m_tvalid && (m_tuser == ACT_MARKER), (m_tdata[18:17] == MODE_CHASE) && (m_tdata[7:0] < RING_PIXELS), "bad marker item")

	// a bar frame only in bar mode, with the count in range
	`LRDS_ASSERT_NOW(a_bar_range, m_tvalid && (m_tuser == ACT_BAR), (m_tdata[18:17] == MODE_BAR) && (m_tdata[15:8] <= SOC_PIXELS), "bad bar item")

	// an accepted start always draws
	`LRDS_ASSERT_NOW(a_accept_frame, m_tvalid && m_tdata[16], (m_tuser == ACT_CLEAR) || (m_tuser == ACT_BAR), "accepted start without frame")

endmodule

bind led_ring_diagnostic_sequencer_top lrds_chk u_lrds_chk (.*);

### test/led_ring_diagnostic_sequencer_top_tb.sv
`timescale 1ns / 1ps
module led_ring_diagnostic_sequencer_top_tb;
	import lrds_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;
	localparam logic [31:0] BAR_T0 = 32'hFFFF_FF00;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] marker;
		logic [7:0] segs;
		logic       accepted;
		logic [1:0] mode;
	} frame_t;

	class led_frame_scoreboard;
		logic        rail_on;
		logic [15:0] chase_step;
		logic [15:0] bar_step;
		logic [23:0] bar_leg;
		logic [23:0] bar_pause;
		logic [23:0] bar_total;
		logic [1:0]  mode;
		logic [7:0]  chase_pos;
		logic [31:0] chase_last;
		logic [31:0] bar_origin;
		logic [7:0]  bar_shown;
		frame_t      expected_frames[$];
		int          mismatches;

		function new();
			rail_on    = 1'b1;
			chase_step = CHASE_STEP_RST;
			bar_step   = BAR_STEP_RST;
			bar_leg    = BAR_LEG_RST;
			bar_pause  = BAR_PAUSE_RST;
			bar_total  = BAR_TOTAL_RST;
			mode       = MODE_IDLE;
			chase_pos  = '0;
			chase_last = '0;
			bar_origin = '0;
			bar_shown  = '0;
			mismatches = 0;
		endfunction

		function void load_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				CFG_RAIL:       rail_on    = val[0];
				CFG_CHASE_STEP: chase_step = val[15:0];
				CFG_BAR_STEP:   bar_step   = val[15:0];
				CFG_BAR_LEG:    bar_leg    = val;
				CFG_BAR_PAUSE:  bar_pause  = val;
				CFG_BAR_TOTAL:  bar_total  = val;
				default: ;
			endcase
		endfunction

		// segment count for a bar test at the given elapsed time
		function logic [7:0] bar_level(logic [31:0] elapsed);
			logic [31:0] stp;
			logic [31:0] hold_end;
			logic [31:0] d;
			stp = (bar_step == '0) ? 32'd1 : {16'd0, bar_step};
			hold_end = {8'd0, bar_leg} + {8'd0, bar_pause};
			if (elapsed < {8'd0, bar_leg}) begin
				d = elapsed / stp;
				return (d > {24'd0, SOC_PIXELS}) ? SOC_PIXELS : d[7:0];
			end
			if (elapsed < hold_end)
				return SOC_PIXELS;
			d = (elapsed - hold_end) / stp;
			return (d >= {24'd0, SOC_PIXELS}) ? 8'd0 : SOC_PIXELS - d[7:0];
		endfunction

		function void note_request(logic [1:0] req, logic [31:0] stamp);
			frame_t      f;
			logic [31:0] elapsed;
			logic [31:0] since_step;
			logic [7:0]  lvl;
			f = '0;
			if (req == REQ_CHASE || req == REQ_BAR) begin
				if (rail_on) begin
					f.accepted = 1'b1;
					if (req == REQ_CHASE) begin
						mode       = MODE_CHASE;
						chase_pos  = '0;
						chase_last = stamp;
						f.action   = ACT_CLEAR;
					end else begin
						mode       = MODE_BAR;
						bar_origin = stamp;
						bar_shown  = '0;
						f.action   = ACT_BAR;
					end
				end
			end else if (req == REQ_OFF) begin
				mode = MODE_IDLE;
				if (rail_on)
					f.action = ACT_CLEAR;
			end else if (mode != MODE_IDLE) begin
				if (!rail_on) begin
					mode = MODE_IDLE;
				end else if (mode == MODE_BAR) begin
					elapsed = stamp - bar_origin;
					// wrapped past half range: tick is before the start
					if (!elapsed[31]) begin
						if (elapsed >= {8'd0, bar_total}) begin
							mode     = MODE_IDLE;
							f.action = ACT_CLEAR;
						end else begin
							lvl = bar_level(elapsed);
							if (lvl != bar_shown) begin
								bar_shown = lvl;
								f.action  = ACT_BAR;
								f.segs    = lvl;
							end
						end
					end
				end else begin
					since_step = stamp - chase_last;
					if (since_step >= {16'd0, chase_step}) begin
						chase_last = stamp;
						if (chase_pos >= RING_PIXELS) begin
							mode     = MODE_IDLE;
							f.action = ACT_CLEAR;
						end else begin
							f.action  = ACT_MARKER;
							f.marker  = chase_pos;
							chase_pos = chase_pos + 8'd1;
						end
					end
				end
			end
			f.mode = mode;
			expected_frames.push_back(f);
		endfunction

		function void check_frame(logic [1:0] act, logic [23:0] data);
			frame_t got;
			frame_t want;
			got.action   = act;
			got.marker   = data[7:0];
			got.segs     = data[15:8];
			got.accepted = data[16];
			got.mode     = data[18:17];
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: action %0d marker %0d segs %0d acc %0d mode %0d",
						got.action, got.marker, got.segs, got.accepted, got.mode);
				return;
			end
			want = expected_frames.pop_front();
			if (got.action !== want.action || got.marker !== want.marker ||
					got.segs !== want.segs || got.accepted !== want.accepted ||
					got.mode !== want.mode) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("mismatch at %0t: expected act %0d mrk %0d seg %0d acc %0d mode %0d, ",
						$time, want.action, want.marker, want.segs, want.accepted, want.mode);
					$display("got act %0d mrk %0d seg %0d acc %0d mode %0d",
						got.action, got.marker, got.segs, got.accepted, got.mode);
				end
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = REQ_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_RAIL;
	logic [23:0] cfg_data = '0;

	led_frame_scoreboard sb = new();
	int          cycle_count = 0;
	int          burst_left = 0;
	int          sent_count = 0;
	int          stall_cnt = 0;
	int          stall_mode = 0;
	logic [31:0] clock_ms = '0;

	led_ring_diagnostic_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stall pattern, switching at random among three styles
	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt % 64 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (stall_cnt % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_frame(m_tuser, m_tdata);
	end

	task automatic send_request(input logic [1:0] req, input logic [31:0] stamp);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = stamp;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent_count++;
		sb.note_request(req, stamp);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid   = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [2:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		sb.load_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic rail, input logic [15:0] cs, input logic [15:0] bs,
			input logic [23:0] leg, input logic [23:0] pause, input logic [23:0] total);
		drain();
		program_reg(CFG_RAIL, {23'd0, rail});
		program_reg(CFG_CHASE_STEP, {8'd0, cs});
		program_reg(CFG_BAR_STEP, {8'd0, bs});
		program_reg(CFG_BAR_LEG, leg);
		program_reg(CFG_BAR_PAUSE, pause);
		program_reg(CFG_BAR_TOTAL, total);
		// writes to unused indexes must change nothing
		program_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
		clock_ms = $urandom;
	endtask

	task automatic run_random(input int count);
		int target;
		int pick;
		int len;
		int roll;
		int unsigned cs;
		int unsigned span;
		logic [31:0] origin;
		logic [1:0] req;
		target = sent_count + count;
		while (sent_count < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				// chase lap: mostly ticks that advance the marker
				send_request(REQ_CHASE, clock_ms);
				cs  = {16'd0, sb.chase_step};
				len = $urandom_range(8, 40);
				for (int i = 0; i < len && sent_count < target; i++) begin
					if ($urandom_range(0, 3) != 0)
						clock_ms += cs + $urandom_range(0, cs / 2 + 1);
					else
						clock_ms += $urandom_range(0, cs);
					send_request(REQ_TICK, clock_ms);
				end
			end else if (pick < 8) begin
				origin = clock_ms;
				send_request(REQ_BAR, clock_ms);
				span = {8'd0, sb.bar_total} / 12 + 2;
				len  = $urandom_range(10, 45);
				for (int i = 0; i < len && sent_count < target; i++) begin
					roll = $urandom_range(0, 19);
					if (roll == 0) begin
						send_request(REQ_TICK, origin - $urandom_range(1, 5000));
					end else begin
						if (roll == 1)
							clock_ms += $urandom;
						else
							clock_ms += $urandom_range(0, span);
						send_request(REQ_TICK, clock_ms);
					end
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len && sent_count < target; i++) begin
					req = 2'($urandom_range(0, 3));
					if ($urandom_range(0, 1))
						send_request(req, $urandom);
					else begin
						clock_ms += $urandom_range(0, 500);
						send_request(req, clock_ms);
					end
				end
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part on reset settings
		send_request(REQ_TICK, 32'd0);
		send_request(REQ_OFF, 32'd0);
		send_request(REQ_CHASE, 32'd1000);
		send_request(REQ_TICK, 32'd1099);
		send_request(REQ_TICK, 32'd1100);
		send_request(REQ_TICK, 32'd1200);
		send_request(REQ_TICK, 32'd1250);
		send_request(REQ_OFF, 32'd1300);
		send_request(REQ_BAR, BAR_T0);
		send_request(REQ_TICK, BAR_T0 - 32'd256);
		send_request(REQ_TICK, BAR_T0 + 32'd250);
		send_request(REQ_TICK, BAR_T0 + 32'd1999);
		send_request(REQ_TICK, BAR_T0 + 32'd2000);
		send_request(REQ_TICK, BAR_T0 + 32'd2749);
		send_request(REQ_TICK, BAR_T0 + 32'd2750);
		send_request(REQ_TICK, BAR_T0 + 32'd4999);
		send_request(REQ_TICK, BAR_T0 + 32'd5000);
		send_request(REQ_TICK, BAR_T0 + 32'd5001);
		send_request(REQ_BAR, 32'hFFFF_FFFF);
		send_request(REQ_TICK, 32'hFFFF_FFFF);
		send_request(REQ_CHASE, 32'd0);
		clock_ms = $urandom;
		run_random(120);

		apply_settings(1'b1, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0);
		run_random(120);
		apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		run_random(120);

		// leave a chase running so the unpowered tick drops it
		drain();
		program_reg(CFG_RAIL, 24'd1);
		send_request(REQ_CHASE, clock_ms);
		apply_settings(1'b0, 16'd20, 16'd30, 24'd200, 24'd100, 24'd600);
		run_random(100);

		apply_settings(1'b1, 16'd1, 16'd1, 24'd8, 24'd3, 24'd30);
		run_random(120);

		for (int p = 0; p < 4; p++) begin
			apply_settings($urandom_range(0, 5) != 0, 16'($urandom_range(0, 300)),
				16'($urandom_range(0, 400)), 24'($urandom_range(0, 4000)),
				24'($urandom_range(0, 2000)), 24'($urandom_range(0, 10000)));
			run_random(120);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
